// ===== rtl/eskm_pkg.sv =====
`default_nettype none

package eskm_pkg;

    localparam int NUM_KEYS_DEF    = 26;
    localparam int MAX_SEQ_LEN_DEF = 3;
    localparam int TABLE_ROWS      = 26;

    localparam logic [7:0] ESC = 8'h1B;
    localparam logic [7:0] CSI = 8'h9B;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [3:0] len;
        logic [7:0] s0;
        logic [7:0] s1;
        logic [7:0] s2;
        logic [7:0] code;
    } t_key_entry;

    localparam t_key_entry KEY_TABLE [TABLE_ROWS] = '{
        '{4'd3, ESC, 8'h4F, 8'h44, 8'h02}, '{4'd3, ESC, 8'h4F, 8'h43, 8'h06},
        '{4'd3, ESC, 8'h4F, 8'h41, 8'h10}, '{4'd3, ESC, 8'h4F, 8'h42, 8'h0E},
        '{4'd3, ESC, 8'h5B, 8'h44, 8'h02}, '{4'd3, ESC, 8'h5B, 8'h43, 8'h06},
        '{4'd3, ESC, 8'h5B, 8'h41, 8'h10}, '{4'd3, ESC, 8'h5B, 8'h42, 8'h0E},
        '{4'd2, CSI, 8'h44, 8'h00, 8'h02}, '{4'd2, CSI, 8'h43, 8'h00, 8'h06},
        '{4'd2, CSI, 8'h41, 8'h00, 8'h10}, '{4'd2, CSI, 8'h42, 8'h00, 8'h0E},
        '{4'd3, ESC, 8'h4F, 8'h70, 8'h30}, '{4'd3, ESC, 8'h4F, 8'h71, 8'h31},
        '{4'd3, ESC, 8'h4F, 8'h72, 8'h32}, '{4'd3, ESC, 8'h4F, 8'h73, 8'h33},
        '{4'd3, ESC, 8'h4F, 8'h74, 8'h34}, '{4'd3, ESC, 8'h4F, 8'h75, 8'h35},
        '{4'd3, ESC, 8'h4F, 8'h76, 8'h36}, '{4'd3, ESC, 8'h4F, 8'h77, 8'h37},
        '{4'd3, ESC, 8'h4F, 8'h78, 8'h38}, '{4'd3, ESC, 8'h4F, 8'h79, 8'h39},
        '{4'd3, ESC, 8'h4F, 8'h6D, 8'h2D}, '{4'd3, ESC, 8'h4F, 8'h6C, 8'h2C},
        '{4'd3, ESC, 8'h4F, 8'h6E, 8'h2E}, '{4'd3, ESC, 8'h4F, 8'h4D, 8'h0D}
    };

    // sequence length of a row, zero for rows outside the table
    function automatic int key_len(input int row);
        int result;
        result = 0;
        if (row >= 0 && row < TABLE_ROWS) begin
            result = int'(KEY_TABLE[row].len);
        end
        return result;
    endfunction

    function automatic logic key_present(input int row, input int max_len);
        logic result;
        result = (key_len(row) >= 1) && (key_len(row) <= max_len);
        return result;
    endfunction

    function automatic logic [7:0] key_byte(input int row, input int pos);
        logic [7:0] result;
        result = 8'h00;
        if (row >= 0 && row < TABLE_ROWS) begin
            case (pos)
                0:       result = KEY_TABLE[row].s0;
                1:       result = KEY_TABLE[row].s1;
                2:       result = KEY_TABLE[row].s2;
                default: result = 8'h00;
            endcase
        end
        return result;
    endfunction

    function automatic logic [7:0] key_code(input int row);
        logic [7:0] result;
        result = 8'h00;
        if (row >= 0 && row < TABLE_ROWS) begin
            result = KEY_TABLE[row].code;
        end
        return result;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/escape_sequence_key_mapper_core.sv =====
// scan: each input byte is compared against one table entry per cycle, and a
// completed sequence ends the scan early; each result byte is then loaded into the
// output register when it is free. A single entry compare unit does the scan, and
// o_stall holds off the next input byte until the current one is fully handled
// reset: synchronous active low, clears all match progress and the output valid
`default_nettype none

module escape_sequence_key_mapper_core #(
    parameter int NUM_KEYS    = eskm_pkg::NUM_KEYS_DEF,
    parameter int MAX_SEQ_LEN = eskm_pkg::MAX_SEQ_LEN_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_in_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_last_of_run
);

    localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int PW    = (MAX_SEQ_LEN > 2) ? $clog2(MAX_SEQ_LEN) : 1;

    eskm_pkg::t_state r_state, n_state;
    logic [PW-1:0]    r_prog [NUM_KEYS];
    logic [PW-1:0]    n_prog [NUM_KEYS];
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [7:0]       r_byte, n_byte;
    logic             r_adv, n_adv;
    logic [PW-1:0]    r_best_prog, n_best_prog;
    logic [IDX_W-1:0] r_best_idx, n_best_idx;
    logic [PW-1:0]    r_k, n_k;
    logic             r_o_valid, n_o_valid;
    logic [7:0]       r_o_byte, n_o_byte;
    logic             r_o_last, n_o_last;

    logic [PW-1:0] cur_p;
    logic          cur_present;
    logic          cur_hit;
    logic          cur_done;
    logic          out_free;

    always_comb begin
        cur_p       = r_prog[r_idx];
        cur_present = eskm_pkg::key_present(int'(r_idx), MAX_SEQ_LEN);
        cur_hit     = cur_present && (int'(cur_p) < eskm_pkg::key_len(int'(r_idx)))
                      && (eskm_pkg::key_byte(int'(r_idx), int'(cur_p)) == r_byte);
        cur_done    = cur_hit && ((int'(cur_p) + 1) == eskm_pkg::key_len(int'(r_idx)));
        out_free    = !r_o_valid || !i_stall;
    end

    always_comb begin
        n_state     = r_state;
        n_prog      = r_prog;
        n_idx       = r_idx;
        n_byte      = r_byte;
        n_adv       = r_adv;
        n_best_prog = r_best_prog;
        n_best_idx  = r_best_idx;
        n_k         = r_k;
        n_o_valid   = r_o_valid && i_stall;
        n_o_byte    = r_o_byte;
        n_o_last    = r_o_last;

        case (r_state)
            eskm_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_byte      = i_in_byte;
                    n_idx       = '0;
                    n_adv       = 1'b0;
                    n_best_prog = '0;
                    n_best_idx  = '0;
                    n_state     = eskm_pkg::S_SCAN;
                end
            end
            eskm_pkg::S_SCAN: begin
                // best is taken from the old progress, only used when nothing advanced
                if (cur_present && (cur_p > r_best_prog)) begin
                    n_best_prog = cur_p;
                    n_best_idx  = r_idx;
                end
                if (cur_done) begin
                    // completed sequence: emit its code alone, progress clears on emit
                    n_byte      = eskm_pkg::key_code(int'(r_idx));
                    n_best_prog = '0;
                    n_k         = '0;
                    n_state     = eskm_pkg::S_EMIT;
                end else begin
                    if (cur_hit) begin
                        n_prog[r_idx] = PW'(int'(cur_p) + 1);
                        n_adv         = 1'b1;
                    end
                    if (r_idx == IDX_W'(NUM_KEYS - 1)) begin
                        n_k = '0;
                        if (r_adv || cur_hit) begin
                            n_state = eskm_pkg::S_IDLE;
                        end else begin
                            n_state = eskm_pkg::S_EMIT;
                        end
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            eskm_pkg::S_EMIT: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    if (r_k == r_best_prog) begin
                        n_o_byte = r_byte;
                        n_o_last = 1'b1;
                        for (int i = 0; i < NUM_KEYS; i++) begin
                            n_prog[i] = '0;
                        end
                        n_state = eskm_pkg::S_IDLE;
                    end else begin
                        n_o_byte = eskm_pkg::key_byte(int'(r_best_idx), int'(r_k));
                        n_o_last = 1'b0;
                        n_k      = r_k + 1'b1;
                    end
                end
            end
            default: begin
                n_state = eskm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= eskm_pkg::S_IDLE;
            r_o_valid <= 1'b0;
            for (int i = 0; i < NUM_KEYS; i++) begin
                r_prog[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            r_prog    <= n_prog;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_byte      <= n_byte;
        r_adv       <= n_adv;
        r_best_prog <= n_best_prog;
        r_best_idx  <= n_best_idx;
        r_k         <= n_k;
        r_o_byte    <= n_o_byte;
        r_o_last    <= n_o_last;
    end

    assign o_stall       = (r_state != eskm_pkg::S_IDLE);
    assign o_valid       = r_o_valid;
    assign o_out_byte    = r_o_byte;
    assign o_last_of_run = r_o_last;

`ifndef SYNTH
    // an accepted transaction starts the scan at the first entry
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == eskm_pkg::S_SCAN && r_idx == '0))
        else $error("scan did not start at entry zero");

    // a result that is not the last of its run means more bytes are still queued
    a_run_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_of_run) |-> (r_state == eskm_pkg::S_EMIT))
        else $error("run ended without a last byte");

    // flush counter never passes the stored prefix length
    a_flush_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == eskm_pkg::S_EMIT) |-> (r_k <= r_best_prog))
        else $error("flush counter overran prefix");
`endif

endmodule

`default_nettype wire
